// File: hdl/pl_pkg.sv
// Shared types and constants for the positional list block.
package pl_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int POS_W            = 8;
   localparam int VALUE_W          = 32;
   localparam int LEN_W            = 6;
   localparam int OP_W             = 2;
   localparam int STATUS_W         = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_SPARE = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic               insert;
      logic               remove;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

// File: hdl/pl_cell.sv
// One entry of the shift chain; takes a new value, or its left/right neighbor.
module pl_cell #(
   parameter int INDEX = 0
) (
   input  logic                          clock,
   input  pl_pkg::cell_cmd_type          cmd,
   input  logic [pl_pkg::VALUE_W-1:0]    left_data,
   input  logic [pl_pkg::VALUE_W-1:0]    right_data,
   output logic [pl_pkg::VALUE_W-1:0]    entry
);

   localparam logic [pl_pkg::POS_W:0] MY_POS = (pl_pkg::POS_W+1)'(INDEX);

   logic [pl_pkg::VALUE_W-1:0] entry_ff;
   logic [pl_pkg::VALUE_W-1:0] entry_in;
   logic [pl_pkg::POS_W:0]     pos_ext;

   assign pos_ext = {1'b0, cmd.pos};

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (MY_POS == pos_ext) begin
            entry_in = cmd.value;
         end else if (MY_POS > pos_ext) begin
            entry_in = left_data;
         end
      end else if (cmd.remove && (MY_POS >= pos_ext)) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// File: hdl/positional_list_insert_delete.sv
// Top level of the positional list: command decode, entry count and the cell chain.
//
//   channel | direction | tdata (low bit up)                 | tuser
//   --------+-----------+------------------------------------+---------------
//   req_    | in        | position[7:0], value[39:8]         | operation[1:0]
//   rsp_    | out       | status[1:0], length_after[7:2]     | -
//
// The whole chain of cells shifts at once, so a new beat can be taken on
// every clock while rsp_ is not stalled.
// The result sits in an output register; a new request is taken whenever that
// register is empty or is being drained in the same cycle.
// A stall on rsp_ holds req_tready low until the result beat is taken.
// reset is synchronous, active high; it empties the list (count to zero)
// and drops any pending result. Entry contents are not cleared.
module positional_list_insert_delete #(
   parameter int CAPACITY = pl_pkg::DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[7:0], value[39:8]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // status[1:0], length_after[7:2]
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EXT_W = pl_pkg::POS_W + 1;
   localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);

   // Count of held entries and the registered result.
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   pl_pkg::status_type        rsp_status_ff;
   pl_pkg::status_type        rsp_status_in;
   logic [pl_pkg::LEN_W-1:0]  rsp_len_ff;
   logic [pl_pkg::LEN_W-1:0]  rsp_len_in;

   logic                         accept;
   pl_pkg::op_type               op;
   logic [pl_pkg::POS_W-1:0]     req_pos;
   logic [pl_pkg::VALUE_W-1:0]   req_value;
   logic [EXT_W-1:0]             cnt_ext;
   logic [EXT_W-1:0]             pos_ext;
   logic [EXT_W-1:0]             cnt_next_ext;
   pl_pkg::status_type           status;
   pl_pkg::cell_cmd_type         cmd;

   logic [pl_pkg::VALUE_W-1:0] cell_q [CAPACITY];

   // Take a new beat whenever the output register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign op        = pl_pkg::op_type'(req_tuser);
   assign req_pos   = req_tdata[7:0];
   assign req_value = req_tdata[39:8];
   assign cnt_ext   = EXT_W'(count_ff);
   assign pos_ext   = {1'b0, req_pos};

   // Decode: range check first, then the full check, as the list defines.
   always_comb begin
      cmd.insert = 1'b0;
      cmd.remove = 1'b0;
      cmd.pos    = req_pos;
      cmd.value  = req_value;
      status     = pl_pkg::ST_RANGE;
      case (op)
         pl_pkg::OP_APPEND: begin
            cmd.pos = pl_pkg::POS_W'(count_ff);
            if (cnt_ext == CAP_EXT) begin
               status = pl_pkg::ST_FULL;
            end else begin
               status     = pl_pkg::ST_DONE;
               cmd.insert = accept;
            end
         end
         pl_pkg::OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = pl_pkg::ST_RANGE;
            end else if (cnt_ext == CAP_EXT) begin
               status = pl_pkg::ST_FULL;
            end else begin
               status     = pl_pkg::ST_DONE;
               cmd.insert = accept;
            end
         end
         pl_pkg::OP_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               status = pl_pkg::ST_RANGE;
            end else begin
               status     = pl_pkg::ST_DONE;
               cmd.remove = accept;
            end
         end
         default: begin
            status = pl_pkg::ST_RANGE;
         end
      endcase
   end

   // Advance the count with the chain; hold it on any error.
   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign cnt_next_ext = EXT_W'(count_in);

   // Load the result on accept, drop it once the beat is taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_len_in    = cnt_next_ext[pl_pkg::LEN_W-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_status_ff};

   // Chain of entry cells; cell 0 never takes its left input, the last cell
   // takes zero from the right when an entry is removed.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [pl_pkg::VALUE_W-1:0] left_d;
      logic [pl_pkg::VALUE_W-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = req_value;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = '0;
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end
      pl_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .entry      (cell_q[i])
      );
   end

   // The count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      EXT_W'(count_ff) <= CAP_EXT)
      else $error("entry count above capacity");

   // A pending result always reports the current count.
   a_len_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_len_ff == cnt_ext[pl_pkg::LEN_W-1:0])
      else $error("reported length differs from count");

   // A full status is only given when the list is at capacity.
   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == pl_pkg::ST_FULL) |-> cnt_ext == CAP_EXT)
      else $error("full status below capacity");

   // A successful insert grows the list by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list by one");

   // A rejected operation leaves the count as it was.
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && status != pl_pkg::ST_DONE) |=> count_ff == $past(count_ff))
      else $error("failed operation changed the count");

endmodule
